// ----- src/dmc_pkg.sv -----
// ----------------------------------------------------------------------------
// dmc_pkg: shared types and constants of the maze carver
// Field widths, item and result structs, direction and mode codes, and the
// sequencer states.
// ----------------------------------------------------------------------------
package dmc_pkg;

	localparam int CFG_W      = 13;
	localparam int CFG_IDX_W  = 1;
	localparam int CELL_OUT_W = 12;
	localparam int RAND_W     = 32;
	localparam int WALL_W     = 4;

	// Cell word: bits 3..0 are the walls, bit 4 is the visited flag.
	localparam int CELL_W      = WALL_W + 1;
	localparam int VISITED_BIT = WALL_W;

	localparam logic [WALL_W-1:0] WALLS_ALL = 4'b1111;

	localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b1;

	localparam logic MODE_STEP    = 1'b0;
	localparam logic MODE_RESTART = 1'b1;

	localparam logic [1:0] DIR_TOP    = 2'd0;
	localparam logic [1:0] DIR_RIGHT  = 2'd1;
	localparam logic [1:0] DIR_BOTTOM = 2'd2;
	localparam logic [1:0] DIR_LEFT   = 2'd3;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD,
		ST_GATHER,
		ST_PICK,
		ST_WNB,
		ST_WCUR,
		ST_DONE
	} dmc_state_t;

	typedef struct packed {
		logic              mode;
		logic [RAND_W-1:0] random_value;
	} dmc_in_t;

	typedef struct packed {
		logic [CELL_OUT_W-1:0] popped_cell;
		logic [CELL_OUT_W-1:0] carved_cell;
		logic [1:0]            carve_direction;
		logic                  carved;
		logic [WALL_W-1:0]     popped_walls;
		logic [WALL_W-1:0]     carved_walls;
		logic                  finished;
	} dmc_out_t;

endpackage

// ----- src/dmc_mod_unit.sv -----
// ----------------------------------------------------------------------------
// dmc_mod_unit: iterative remainder unit
// Restoring division, one dividend bit per cycle; rem holds numer % denom
// once busy drops. denom must be nonzero and stay stable while busy.
// ----------------------------------------------------------------------------
module dmc_mod_unit #(
	parameter int NUM_W = 12,
	parameter int DEN_W = 13
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] numer,
	input  logic [DEN_W-1:0] denom,
	output logic             busy,
	output logic [DEN_W-1:0] rem
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] numer_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;

	assign trial = {rem_q, numer_q[NUM_W-1]};
	// The top bit of diff is the borrow, since trial is below twice denom.
	assign diff  = trial - {1'b0, denom};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(NUM_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			numer_q <= numer;
			rem_q   <= '0;
		end else if (cnt_q != '0) begin
			numer_q <= {numer_q[NUM_W-2:0], 1'b0};
			rem_q   <= diff[DEN_W] ? trial[DEN_W-1:0] : diff[DEN_W-1:0];
		end
	end

	assign busy = (cnt_q != '0);
	assign rem  = rem_q;

endmodule

// ----- src/dfs_maze_carver_core.sv -----
// ----------------------------------------------------------------------------
// dfs_maze_carver_core: depth-first (recursive backtracker) maze carver
// Cell walls and the walk stack live in two single-port synchronous memories.
//
// Channels: item (mode, random_value) and result use valid/ready; cfg writes
// grid_cols (index 0) and grid_rows (index 1) and is always ready. Write cfg
// only while no item is in flight.
// Every item gives exactly one result. A step with an empty stack goes
// straight to the done state. A step that pops a cell first reads the stack
// top in the load state, then reads five cell words (the cell and its four
// neighbors) while the remainder unit works out the column, one bit per cycle;
// a pick state then chooses a neighbor. A pure backtrack then goes to the done
// state; a carve first writes two cell words and pushes two cells.
// One item is worked on at a time; the next is accepted once the result
// enters the output register, so a result may wait there while the next item
// runs. If the receiver stalls, the finished result holds and the next item
// waits in the done state until the output register frees up.
// Reset, and every restart item, sweeps the cell memory one entry per cycle
// to all walls and unvisited (cell 0 visited after a restart); no item is taken meanwhile.
// ----------------------------------------------------------------------------
module dfs_maze_carver_core
	import dmc_pkg::*;
#(
	parameter int MAX_CELLS = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  dmc_in_t              item,
	output logic                 result_valid,
	input  logic                 result_ready,
	output dmc_out_t             result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int CW   = $clog2(MAX_CELLS);
	localparam int CNTW = $clog2(MAX_CELLS + 1);
	localparam int AW   = ((CW > CFG_W) ? CW : CFG_W) + 2;
	localparam int AREA_W = 2 * CFG_W;
	localparam int SLOTS  = 5;

	localparam logic [2:0] SLOT_CUR    = 3'd0;
	localparam logic [2:0] SLOT_TOP    = 3'd1;
	localparam logic [2:0] SLOT_RIGHT  = 3'd2;
	localparam logic [2:0] SLOT_BOTTOM = 3'd3;
	localparam logic [2:0] SLOT_LEFT   = 3'd4;
	localparam logic [2:0] SLOT_END    = 3'd5;

	function automatic logic [1:0] mod3_32(input logic [RAND_W-1:0] v);
		logic [5:0] s;
		logic [3:0] t;
		logic [1:0] r;
		s = '0;
		// 4 is 1 mod 3, so the base-4 digit sum keeps the residue.
		for (int i = 0; i < RAND_W / 4; i++) begin
			s = s + 6'(v[4*i +: 2]) + 6'(v[4*i+2 +: 2]);
		end
		t = 4'(s[1:0]) + 4'(s[3:2]) + 4'(s[5:4]);
		unique case (t)
			4'd0, 4'd3, 4'd6, 4'd9: r = 2'd0;
			4'd1, 4'd4, 4'd7:       r = 2'd1;
			4'd2, 4'd5, 4'd8:       r = 2'd2;
			default:                r = 2'd0;
		endcase
		return r;
	endfunction

	dmc_state_t state_q, state_d;

	logic [CFG_W-1:0]  cols_q, rows_q, cols_eff, rows_eff, cols_eff_q;
	logic [AREA_W-1:0] area;
	logic [CNTW-1:0]   total_d, total_q;

	logic [CNTW-1:0]   stack_count_q;
	logic              stack_full;
	logic [CW-1:0]     clr_addr_q;
	logic              restart_q;
	logic              clr_last;

	logic [CELL_W-1:0] cell_mem [MAX_CELLS];
	logic              cell_we;
	logic [CW-1:0]     cell_addr;
	logic [CELL_W-1:0] cell_wdata;
	logic [CELL_W-1:0] cell_rd_q;

	logic [CW-1:0]     stack_mem [MAX_CELLS];
	logic              stack_we;
	logic [CW-1:0]     stack_addr;
	logic [CW-1:0]     stack_wdata;
	logic [CW-1:0]     stack_rd_q;

	logic [CW-1:0]     cur_q, nb_q, nb_d;
	logic [1:0]        r2_q, r3_q;
	logic [2:0]        rd_idx_q, cap_idx_q;
	logic              cap_valid_q;
	logic [CELL_W-1:0] slot_q [SLOTS];
	logic              gather_done;
	logic [CW-1:0]     gather_addr;

	logic              div_start, div_busy;
	logic [CFG_W-1:0]  div_rem;

	logic [AW-1:0]     cur_w, cols_w, tot_w, up_w, right_w, down_w, left_w;
	logic [3:0]        open_dirs;
	logic              any_open;
	logic [2:0]        n_open, seen;
	logic [1:0]        pick, sel_dir, opp_dir;
	logic [CELL_W-1:0] nb_cell;
	logic [WALL_W-1:0] cur_mask, nb_mask;

	dmc_out_t          pend_q, out_q, pend_init;
	logic              out_valid_q, out_load;
	logic              accept;

	// Grid size, registered every cycle.
	assign cols_eff = (cols_q == '0) ? CFG_W'(1) : cols_q;
	assign rows_eff = (rows_q == '0) ? CFG_W'(1) : rows_q;
	assign area     = AREA_W'(cols_eff) * AREA_W'(rows_eff);
	assign total_d  = (area > AREA_W'(MAX_CELLS)) ? CNTW'(MAX_CELLS) : CNTW'(area);

	assign stack_full = (stack_count_q == CNTW'(MAX_CELLS));
	assign clr_last   = (clr_addr_q == CW'(MAX_CELLS - 1));
	assign accept     = item_valid && item_ready;
	assign cfg_ready  = 1'b1;

	// Neighbor arithmetic, wide enough for every sum and compare.
	assign cur_w   = AW'(cur_q);
	assign cols_w  = AW'(cols_eff_q);
	assign tot_w   = AW'(total_q);
	assign up_w    = cur_w - cols_w;
	assign right_w = cur_w + AW'(1);
	assign down_w  = cur_w + cols_w;
	assign left_w  = cur_w - AW'(1);

	always_comb begin
		unique case (rd_idx_q)
			SLOT_TOP:    gather_addr = up_w[CW-1:0];
			SLOT_RIGHT:  gather_addr = right_w[CW-1:0];
			SLOT_BOTTOM: gather_addr = down_w[CW-1:0];
			SLOT_LEFT:   gather_addr = left_w[CW-1:0];
			default:     gather_addr = cur_q;
		endcase
	end

	assign gather_done = (rd_idx_q == SLOT_END) && !cap_valid_q && !div_busy;

	dmc_mod_unit #(
		.NUM_W (CW),
		.DEN_W (CFG_W)
	) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (stack_rd_q),
		.denom  (cols_eff_q),
		.busy   (div_busy),
		.rem    (div_rem)
	);

	// Open neighbors; right and left must share the row of the popped cell.
	assign open_dirs[DIR_TOP] = (cur_w >= cols_w) && (up_w < tot_w)
		&& !slot_q[SLOT_TOP][VISITED_BIT];
	assign open_dirs[DIR_RIGHT] = (div_rem != cols_eff_q - CFG_W'(1)) && (right_w < tot_w)
		&& !slot_q[SLOT_RIGHT][VISITED_BIT];
	assign open_dirs[DIR_BOTTOM] = (down_w < tot_w) && !slot_q[SLOT_BOTTOM][VISITED_BIT];
	assign open_dirs[DIR_LEFT] = (div_rem != '0) && (left_w < tot_w)
		&& !slot_q[SLOT_LEFT][VISITED_BIT];

	assign n_open   = 3'($countones(open_dirs));
	assign any_open = (open_dirs != '0);

	always_comb begin
		unique case (n_open)
			3'd2:    pick = {1'b0, r2_q[0]};
			3'd3:    pick = r3_q;
			3'd4:    pick = r2_q;
			default: pick = 2'd0;
		endcase
	end

	always_comb begin
		sel_dir = DIR_TOP;
		seen    = '0;
		for (int d = 0; d < 4; d++) begin
			if (open_dirs[d]) begin
				if (seen == {1'b0, pick}) begin
					sel_dir = 2'(d);
				end
				seen = seen + 3'd1;
			end
		end
	end

	assign opp_dir  = sel_dir + 2'd2;
	assign cur_mask = WALL_W'(1) << sel_dir;
	assign nb_mask  = WALL_W'(1) << opp_dir;

	always_comb begin
		unique case (sel_dir)
			DIR_TOP: begin
				nb_d    = up_w[CW-1:0];
				nb_cell = slot_q[SLOT_TOP];
			end
			DIR_RIGHT: begin
				nb_d    = right_w[CW-1:0];
				nb_cell = slot_q[SLOT_RIGHT];
			end
			DIR_BOTTOM: begin
				nb_d    = down_w[CW-1:0];
				nb_cell = slot_q[SLOT_BOTTOM];
			end
			default: begin
				nb_d    = left_w[CW-1:0];
				nb_cell = slot_q[SLOT_LEFT];
			end
		endcase
	end

	// Result of an item that needs no cell walk: restart or empty stack.
	always_comb begin
		pend_init = '0;
		if (item.mode == MODE_RESTART) begin
			pend_init.popped_walls = WALLS_ALL;
		end else begin
			pend_init.finished = 1'b1;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_last) begin
					state_d = restart_q ? ST_DONE : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (item_valid) begin
					priority if (item.mode == MODE_RESTART) begin
						state_d = ST_CLEAR;
					end else if (stack_count_q == '0) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_LOAD;
					end
				end
			end
			ST_LOAD:   state_d = ST_GATHER;
			ST_GATHER: begin
				if (gather_done) begin
					state_d = ST_PICK;
				end
			end
			ST_PICK:   state_d = any_open ? ST_WNB : ST_DONE;
			ST_WNB:    state_d = ST_WCUR;
			ST_WCUR:   state_d = ST_DONE;
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// Memory controls and handshake.
	always_comb begin
		item_ready  = 1'b0;
		cell_we     = 1'b0;
		cell_addr   = clr_addr_q;
		cell_wdata  = {1'b0, WALLS_ALL};
		stack_we    = 1'b0;
		stack_addr  = CW'(stack_count_q);
		stack_wdata = cur_q;
		div_start   = 1'b0;
		out_load    = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cell_we = 1'b1;
				// A restart leaves cell 0 visited and pushed.
				if (restart_q && clr_addr_q == '0) begin
					cell_wdata  = {1'b1, WALLS_ALL};
					stack_we    = 1'b1;
					stack_addr  = '0;
					stack_wdata = '0;
				end
			end
			ST_IDLE: begin
				item_ready = 1'b1;
				stack_addr = CW'(stack_count_q - CNTW'(1));
			end
			ST_LOAD: begin
				div_start = 1'b1;
			end
			ST_GATHER: begin
				cell_addr = gather_addr;
			end
			ST_PICK: begin
				cell_addr = cur_q;
			end
			ST_WNB: begin
				cell_we     = 1'b1;
				cell_addr   = nb_q;
				cell_wdata  = {1'b1, pend_q.carved_walls};
				stack_we    = !stack_full;
				stack_wdata = cur_q;
			end
			ST_WCUR: begin
				cell_we     = 1'b1;
				cell_addr   = cur_q;
				cell_wdata  = {slot_q[SLOT_CUR][VISITED_BIT], pend_q.popped_walls};
				stack_we    = !stack_full;
				stack_wdata = nb_q;
			end
			ST_DONE: begin
				out_load = !out_valid_q || result_ready;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cell_we) begin
			cell_mem[cell_addr] <= cell_wdata;
		end
		cell_rd_q <= cell_mem[cell_addr];
	end

	always_ff @(posedge clk) begin
		if (stack_we) begin
			stack_mem[stack_addr] <= stack_wdata;
		end
		stack_rd_q <= stack_mem[stack_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			cols_q        <= CFG_W'(16);
			rows_q        <= CFG_W'(16);
			stack_count_q <= '0;
			clr_addr_q    <= '0;
			restart_q     <= 1'b0;
			rd_idx_q      <= '0;
			cap_valid_q   <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_COLS) begin
					cols_q <= cfg_data;
				end else if (cfg_index == CFG_ROWS) begin
					rows_q <= cfg_data;
				end
			end

			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_last ? '0 : clr_addr_q + 1'b1;
				if (clr_last) begin
					restart_q <= 1'b0;
				end
			end

			if (accept) begin
				if (item.mode == MODE_RESTART) begin
					restart_q     <= 1'b1;
					stack_count_q <= CNTW'(1);
				end else if (stack_count_q != '0) begin
					stack_count_q <= stack_count_q - 1'b1;
				end
			end

			if ((state_q == ST_WNB || state_q == ST_WCUR) && !stack_full) begin
				stack_count_q <= stack_count_q + 1'b1;
			end

			if (state_q == ST_LOAD) begin
				rd_idx_q    <= SLOT_CUR;
				cap_valid_q <= 1'b0;
			end else if (state_q == ST_GATHER) begin
				if (rd_idx_q != SLOT_END) begin
					rd_idx_q    <= rd_idx_q + 3'd1;
					cap_valid_q <= 1'b1;
				end else begin
					cap_valid_q <= 1'b0;
				end
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cols_eff_q <= cols_eff;
		total_q    <= total_d;

		if (accept) begin
			r2_q   <= item.random_value[1:0];
			r3_q   <= mod3_32(item.random_value);
			pend_q <= pend_init;
		end

		if (state_q == ST_LOAD) begin
			cur_q <= stack_rd_q;
		end

		if (state_q == ST_GATHER && rd_idx_q != SLOT_END) begin
			cap_idx_q <= rd_idx_q;
		end
		if (cap_valid_q) begin
			slot_q[cap_idx_q] <= cell_rd_q;
		end

		if (state_q == ST_PICK) begin
			nb_q                   <= nb_d;
			pend_q.popped_cell     <= CELL_OUT_W'(cur_q);
			pend_q.carved_cell     <= any_open ? CELL_OUT_W'(nb_d) : '0;
			pend_q.carve_direction <= any_open ? sel_dir : DIR_TOP;
			pend_q.carved          <= any_open;
			pend_q.popped_walls    <= any_open ? (slot_q[SLOT_CUR][WALL_W-1:0] & ~cur_mask)
				: slot_q[SLOT_CUR][WALL_W-1:0];
			pend_q.carved_walls    <= any_open ? (nb_cell[WALL_W-1:0] & ~nb_mask) : '0;
			pend_q.finished        <= !any_open && (stack_count_q == '0);
		end

		if (out_load) begin
			out_q <= pend_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		stack_count_q <= CNTW'(MAX_CELLS))
		else $error("walk stack count beyond capacity");

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !item_ready)
		else $error("item taken during the clearing sweep");

	a_pick_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PICK) |-> (!div_busy && rd_idx_q == SLOT_END && !cap_valid_q))
		else $error("neighbor choice made before gather completed");

	a_carve_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.carved) |-> !result.finished)
		else $error("carving result flagged as finished");

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for dfs_maze_carver_core
// A scoreboard keeps its own copy of the grid, the walk stack and the grid
// size, predicts the result of every accepted item and compares it field by
// field with what the core returns. A short directed run covers empty stacks,
// zero and oversized grids and a size change in the middle of a walk; random
// walks over mostly small grids follow, with random gaps on both channels and
// long receiver hold-offs that fill the core.
// ----------------------------------------------------------------------------
module testbench;
	import dmc_pkg::*;

	localparam int MAX_CELLS   = 4096;
	localparam int ITEM_TARGET = 1500;
	localparam int HOLD_CYCLES = 400;
	localparam int MAX_WALK    = 120;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	class maze_scoreboard;
		logic [CFG_W-1:0]  cols_reg;
		logic [CFG_W-1:0]  rows_reg;
		logic [CELL_W-1:0] grid_cell [MAX_CELLS];
		int unsigned       walk [MAX_CELLS];
		int unsigned       depth;
		dmc_out_t          expected_moves [$];
		int                mismatches;

		function new();
			cols_reg = 13'd16;
			rows_reg = 13'd16;
			foreach (grid_cell[i]) grid_cell[i] = {1'b0, WALLS_ALL};
			depth = 0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
			if (index == CFG_COLS) begin
				cols_reg = data;
			end else if (index == CFG_ROWS) begin
				rows_reg = data;
			end
		endfunction

		function bit is_open(int unsigned c, int unsigned total);
			if (c >= total) return 1'b0;
			return !grid_cell[c][VISITED_BIT];
		endfunction

		// A full stack drops the push; a carve always visits a new cell, so
		// this never happens in a legal walk.
		function void push_walk(int unsigned c);
			if (depth < MAX_CELLS) begin
				walk[depth] = c;
				depth++;
			end
		endfunction

		function dmc_out_t carve_next(dmc_in_t it);
			dmc_out_t    r;
			int unsigned cols;
			int unsigned total;
			int unsigned cur;
			int unsigned nb;
			int unsigned n;
			int unsigned pick;
			int unsigned cand [4];
			logic [1:0]  dirs [4];
			logic [1:0]  d;
			logic [1:0]  back;
			r = '0;
			cols = (cols_reg == 0) ? 1 : cols_reg;
			total = cols * ((rows_reg == 0) ? 1 : rows_reg);
			if (total > MAX_CELLS) total = MAX_CELLS;
			if (it.mode == MODE_RESTART) begin
				foreach (grid_cell[i]) grid_cell[i] = {1'b0, WALLS_ALL};
				grid_cell[0][VISITED_BIT] = 1'b1;
				depth = 0;
				push_walk(0);
				r.popped_walls = WALLS_ALL;
				return r;
			end
			if (depth == 0) begin
				r.finished = 1'b1;
				return r;
			end
			depth--;
			cur = walk[depth];
			n = 0;
			// Right and left neighbors must stay in the same row.
			if (cur >= cols && is_open(cur - cols, total)) begin
				cand[n] = cur - cols;
				dirs[n] = DIR_TOP;
				n++;
			end
			if ((cur + 1) % cols != 0 && is_open(cur + 1, total)) begin
				cand[n] = cur + 1;
				dirs[n] = DIR_RIGHT;
				n++;
			end
			if (is_open(cur + cols, total)) begin
				cand[n] = cur + cols;
				dirs[n] = DIR_BOTTOM;
				n++;
			end
			if (cur >= 1 && cur % cols != 0 && is_open(cur - 1, total)) begin
				cand[n] = cur - 1;
				dirs[n] = DIR_LEFT;
				n++;
			end
			r.popped_cell = cur[CELL_OUT_W-1:0];
			if (n > 0) begin
				pick = it.random_value % n;
				nb = cand[pick];
				d = dirs[pick];
				back = d + 2'd2;
				push_walk(cur);
				push_walk(nb);
				grid_cell[nb][VISITED_BIT] = 1'b1;
				grid_cell[cur][d] = 1'b0;
				grid_cell[nb][back] = 1'b0;
				r.carved_cell = nb[CELL_OUT_W-1:0];
				r.carve_direction = d;
				r.carved = 1'b1;
				r.carved_walls = grid_cell[nb][WALL_W-1:0];
			end
			r.popped_walls = grid_cell[cur][WALL_W-1:0];
			r.finished = (depth == 0);
			return r;
		endfunction

		function void note_item(dmc_in_t it);
			expected_moves.insert(expected_moves.size(), carve_next(it));
		endfunction

		function void check_result(dmc_out_t got);
			dmc_out_t want;
			if (expected_moves.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: result with nothing expected: %p", $realtime, got);
				mismatches++;
				return;
			end
			want = expected_moves.pop_front();
			if (got.popped_cell !== want.popped_cell || got.carved_cell !== want.carved_cell ||
					got.carve_direction !== want.carve_direction ||
					got.carved !== want.carved || got.popped_walls !== want.popped_walls ||
					got.carved_walls !== want.carved_walls || got.finished !== want.finished) begin
				if (mismatches < 10) begin
					$display("%0t: expected %p", $realtime, want);
					$display("%0t: actual   %p", $realtime, got);
				end
				mismatches++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 item_valid = 1'b0;
	logic                 item_ready;
	dmc_in_t              item = '0;
	logic                 result_valid;
	logic                 result_ready = 1'b0;
	dmc_out_t             result;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	maze_scoreboard sb = new();
	idle_mode_t     idle_mode = IDLE_NONE;
	int             items_sent = 0;
	int             hold_seq = 0;
	int             hold_seen = 0;
	int             hold_left = 0;

	dfs_maze_carver_core #(
		.MAX_CELLS(MAX_CELLS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Receiver: a requested hold-off wins over the random stalls.
	always @(negedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else if (idle_mode == IDLE_RECEIVER) begin
			result_ready <= ($urandom_range(99) >= 63);
		end else if (idle_mode == IDLE_BOTH) begin
			result_ready <= ($urandom_range(99) >= 21);
		end else begin
			result_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid === 1'b1 && result_ready)
			sb.check_result(result);
	end

	task automatic send_item(input logic mode, input logic [RAND_W-1:0] rnd);
		dmc_in_t it;
		int      gap_pct;
		it.mode = mode;
		it.random_value = rnd;
		gap_pct = (idle_mode == IDLE_SENDER) ? 63 : (idle_mode == IDLE_BOTH) ? 21 : 0;
		@(negedge clk);
		while ($urandom_range(99) < gap_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_ready !== 1'b1);
		sb.note_item(it);
		items_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		sb.write_reg(index, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// The grid size may only change while no item is in flight.
	task automatic settle();
		@(negedge clk);
		item_valid <= 1'b0;
		while (sb.expected_moves.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_grid(input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] rows);
		settle();
		write_reg(CFG_COLS, cols);
		write_reg(CFG_ROWS, rows);
	endtask

	initial begin
		int unsigned      ph;
		int unsigned      n_cells;
		int unsigned      steps;
		logic [CFG_W-1:0] cols;
		logic [CFG_W-1:0] rows;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Step on an empty stack right after reset.
		send_item(MODE_STEP, 32'h0);
		// Zero sizes count as a single cell.
		set_grid(13'd0, 13'd0);
		send_item(MODE_RESTART, 32'hFFFF_FFFF);
		send_item(MODE_STEP, 32'hFFFF_FFFF);
		send_item(MODE_STEP, 32'h0);
		// A full walk of a 2x2 grid down to the empty stack.
		set_grid(13'd2, 13'd2);
		send_item(MODE_RESTART, 32'h0);
		for (int i = 0; i < 7; i++)
			send_item(MODE_STEP, (i % 3 == 0) ? 32'h0 : (i % 3 == 1) ? 32'hFFFF_FFFF : 32'h3);
		// Oversized grid: the cell count is capped, so this is one long row.
		set_grid(13'h1FFF, 13'h1FFF);
		send_item(MODE_RESTART, 32'h5A5A_5A5A);
		for (int i = 0; i < 3; i++)
			send_item(MODE_STEP, $urandom);
		// Shrink mid-walk: the popped cells now lie outside the grid.
		set_grid(13'd1, 13'd1);
		send_item(MODE_STEP, $urandom);
		send_item(MODE_STEP, $urandom);
		set_grid(13'd4096, 13'd1);
		send_item(MODE_RESTART, 32'h0);
		send_item(MODE_STEP, 32'hFFFF_FFFF);
		send_item(MODE_STEP, 32'h1);
		set_grid(13'd1, 13'd4096);
		send_item(MODE_RESTART, 32'hFFFF_FFFF);
		send_item(MODE_STEP, 32'h0);
		send_item(MODE_STEP, 32'h2);

		items_sent = 0;
		ph = 0;
		while (items_sent < ITEM_TARGET) begin
			settle();
			idle_mode = idle_mode_t'(ph % 4);
			if ($urandom_range(7) == 0) begin
				cols = CFG_W'($urandom_range(8191));
				rows = CFG_W'($urandom_range(8191));
			end else begin
				cols = CFG_W'($urandom_range(1, 8));
				rows = CFG_W'($urandom_range(1, 8));
			end
			write_reg(CFG_COLS, cols);
			write_reg(CFG_ROWS, rows);
			// Most walks start fresh; the rest resume under the new size.
			if (ph == 0 || $urandom_range(4) != 0)
				send_item(MODE_RESTART, $urandom);
			if (ph % 10 == 5)
				hold_seq++;
			n_cells = ((cols == 0) ? 1 : cols) * ((rows == 0) ? 1 : rows);
			if (n_cells * 2 > MAX_WALK)
				steps = $urandom_range(40, MAX_WALK);
			else
				steps = 2 * n_cells + $urandom_range(0, 3);
			for (int i = 0; i < steps; i++) begin
				if (i != steps - 1 && $urandom_range(79) == 0)
					send_item(MODE_RESTART, $urandom);
				else
					send_item(MODE_STEP, $urandom);
			end
			ph++;
		end

		@(negedge clk);
		item_valid <= 1'b0;
		while (sb.expected_moves.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_moves.size() == 0) begin
			$display("dfs_maze_carver_core: match");
		end else begin
			$display("dfs_maze_carver_core: mismatch");
		end
		$finish;
	end

	initial begin
		#60ms;
		$display("dfs_maze_carver_core: mismatch");
		$finish;
	end

endmodule

// ----- sim.f -----
src/dmc_pkg.sv
src/dmc_mod_unit.sv
src/dfs_maze_carver_core.sv
test/testbench.sv
